/* src/assert_macros.svh */
// Assertion macros used by the RTL of the address identifier randomizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside of reset.
`define ADRID_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside of reset.
`define ADRID_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ADRID_ASSERT_IMP(lbl, ante, cons)
`define ADRID_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* src/adrid_pkg.sv */
// Shared constants, codes and types of the address identifier randomizer.
package adrid_pkg;

    // Field and state widths
    localparam int LCG_W     = 48;
    localparam int HALF_W    = 24;
    localparam int WORD_W    = 31;
    localparam int TYPE_W    = 32;
    localparam int CNT_W     = 32;
    localparam int MAXC_W    = 31;
    localparam int OFS_W     = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    // Draws per filled node and words carried by one result
    localparam int ID_WORDS  = 5;
    localparam int OUT_WORDS = 5;
    localparam int DRAW_W    = $clog2(ID_WORDS + 1);

    // Generator: x = (LCG_MUL * x + LCG_ADD) mod 2^48, word = x[47:17]
    localparam logic [LCG_W-1:0] LCG_MUL   = 48'h0005_DEEC_E66D;
    localparam logic [LCG_W-1:0] LCG_ADD   = 48'h0000_0000_000B;
    localparam logic [LCG_W-1:0] DET_RESET = 48'h0003_0002_0001;
    localparam logic [LCG_W-1:0] ARB_RESET = 48'h0006_0005_0004;

    localparam logic [MAXC_W-1:0] MAXC_RESET = 31'd1000000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEW_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFS   = 2'd2;

    // Commands
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_START   = 1'b1;

    // Node types that get rewritten
    localparam logic [TYPE_W-1:0] TYPE_DET = 32'd1;
    localparam logic [TYPE_W-1:0] TYPE_ARB = 32'd2;

    // Fill modes as reported in the result
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ARB  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    // Request to the shared multiply-add unit: res = (a * b + c) mod 2^48
    typedef struct packed {
        logic             start;
        logic [LCG_W-1:0] a;
        logic [LCG_W-1:0] b;
        logic [LCG_W-1:0] c;
    } t_mul_req;

    // Response of the shared multiply-add unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LCG_W-1:0] res;
    } t_mul_rsp;

endpackage

/* src/adrid_in_if.sv */
// Input channel of the address identifier randomizer: command and node type.
interface adrid_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] node_type;

    modport source (output valid, output cmd, output node_type, input ready);
    modport sink   (input valid, input cmd, input node_type, output ready);
endinterface

/* src/adrid_out_if.sv */
// Output channel of the address identifier randomizer: processed node.
interface adrid_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_type;
    logic [1:0]  rewritten;
    logic [30:0] word0;
    logic [30:0] word1;
    logic [30:0] word2;
    logic [30:0] word3;
    logic [30:0] word4;

    modport source (output valid, output out_type, output rewritten, output word0,
                    output word1, output word2, output word3, output word4,
                    input ready);
    modport sink   (input valid, input out_type, input rewritten, input word0,
                    input word1, input word2, input word3, input word4,
                    output ready);
endinterface

/* src/address_id_randomizer_core.sv */
// Top level of the address identifier randomizer: sequencer, generators and registers.
`include "assert_macros.svh"

// Rewrites address nodes of type 1 (deterministic generator) and type 2
// (arbitrary generator) with the configured type and five 31-bit words taken
// from bits 47..17 of a drand48-style 48-bit generator; other types pass
// unchanged with zero words. All 48-bit arithmetic runs on one shared
// multiply-add unit; each operation takes the sequencer through issue, three
// 24x24 partial products, and taking the result. A start command (cmd 1)
// skips both generators ahead by start_offset steps with square-and-multiply:
// for each significant bit of the offset up to four multiply-adds; it produces
// no result. When the fill counter reaches the restart limit the deterministic
// generator is reseeded and skipped the same way after its result is handed
// off. The input is ready only between items; a finished result sits in an
// output register, so the next item is taken while it waits. Configuration
// writes are plain register writes and must only be made while the block is
// idle.
module address_id_randomizer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [adrid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [adrid_pkg::CFG_W-1:0]      i_cfg_data,
    adrid_in_if.sink                         i_in,
    adrid_out_if.source                      o_out
);
    import adrid_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DRAW = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_SKIP = 4'b1000
    } t_state;

    // Steps of one skip iteration
    typedef enum logic [3:0] {
        OP_DET = 4'b0001,
        OP_ARB = 4'b0010,
        OP_BC  = 4'b0100,
        OP_BA  = 4'b1000
    } t_op;

    // Configuration
    logic [TYPE_W-1:0] r_new_type;
    logic [MAXC_W-1:0] r_restart_lim;
    logic [OFS_W-1:0]  r_start_ofs;

    // Control
    t_state            r_state;
    t_op               r_op;
    logic              r_wait;
    logic              r_skip_arb;
    logic              r_reseed;
    logic [DRAW_W-1:0] r_draw;
    logic [OFS_W-1:0]  r_n;
    logic              r_ovalid;

    // Generator state and working values
    logic [LCG_W-1:0]  r_det;
    logic [LCG_W-1:0]  r_arb;
    logic [CNT_W-1:0]  r_cnt;
    logic [LCG_W-1:0]  r_ba;
    logic [LCG_W-1:0]  r_bc;
    logic [MODE_W-1:0] r_mode;
    logic [TYPE_W-1:0] r_type;
    t_word             r_words [OUT_WORDS];

    // Output register
    logic [TYPE_W-1:0] r_o_type;
    logic [MODE_W-1:0] r_o_mode;
    t_word             r_o_words [OUT_WORDS];

    logic [CNT_W-1:0]  n_cnt;
    logic              w_op_need;
    logic              w_out_free;
    logic              w_hand;
    t_mul_req          w_req;
    t_mul_rsp          w_rsp;

    adrid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign n_cnt      = r_cnt + 1'b1;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_hand     = (r_state == ST_FIN) && w_out_free;

    // Whether the current skip step has work at this offset bit
    always_comb begin
        unique case (r_op)
            OP_DET:  w_op_need = r_n[0];
            OP_ARB:  w_op_need = r_n[0] && r_skip_arb;
            default: w_op_need = 1'b1;
        endcase
    end

    // Multiply-add request: a draw step, or one step of the skip
    always_comb begin
        w_req.start = 1'b0;
        w_req.a     = r_ba;
        w_req.b     = r_ba;
        w_req.c     = '0;
        if (r_state == ST_DRAW) begin
            w_req.start = !r_wait;
            w_req.a     = LCG_MUL;
            w_req.b     = (r_mode == MODE_DET) ? r_det : r_arb;
            w_req.c     = LCG_ADD;
        end else if (r_state == ST_SKIP) begin
            w_req.start = !r_wait && (r_n != '0) && w_op_need;
            unique case (r_op)
                OP_DET: begin
                    w_req.b = r_det;
                    w_req.c = r_bc;
                end
                OP_ARB: begin
                    w_req.b = r_arb;
                    w_req.c = r_bc;
                end
                OP_BC: begin
                    w_req.b = r_bc;
                    w_req.c = r_bc;
                end
                default: begin
                    w_req.b = r_ba;
                    w_req.c = '0;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_type    <= '0;
            r_restart_lim <= MAXC_RESET;
            r_start_ofs   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NEW_TYPE:    r_new_type    <= i_cfg_data[TYPE_W-1:0];
                REG_RESTART_LIM: r_restart_lim <= i_cfg_data[MAXC_W-1:0];
                REG_START_OFS:   r_start_ofs   <= i_cfg_data[OFS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Output register: loaded on hand-off, emptied by a result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_hand) begin
            r_ovalid <= 1'b1;
            r_o_type <= r_type;
            r_o_mode <= r_mode;
            for (int k = 0; k < OUT_WORDS; k++) r_o_words[k] <= r_words[k];
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_DET;
            r_wait     <= 1'b0;
            r_skip_arb <= 1'b0;
            r_reseed   <= 1'b0;
            r_draw     <= '0;
            r_n        <= '0;
            r_det      <= DET_RESET;
            r_arb      <= ARB_RESET;
            r_cnt      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.cmd == CMD_START) begin
                            // skip both generators, counter restarts at the offset
                            r_ba       <= LCG_MUL;
                            r_bc       <= LCG_ADD;
                            r_n        <= r_start_ofs;
                            r_op       <= OP_DET;
                            r_skip_arb <= 1'b1;
                            r_cnt      <= CNT_W'(r_start_ofs);
                            r_state    <= ST_SKIP;
                        end else begin
                            r_reseed <= 1'b0;
                            r_draw   <= '0;
                            for (int k = 0; k < OUT_WORDS; k++) r_words[k] <= '0;
                            if (i_in.node_type == TYPE_DET || i_in.node_type == TYPE_ARB) begin
                                r_mode  <= (i_in.node_type == TYPE_DET) ? MODE_DET : MODE_ARB;
                                r_type  <= r_new_type;
                                r_state <= ST_DRAW;
                            end else begin
                                r_mode  <= MODE_NONE;
                                r_type  <= i_in.node_type;
                                r_state <= ST_FIN;
                            end
                        end
                    end
                end

                ST_DRAW: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        if (r_mode == MODE_DET) r_det <= w_rsp.res;
                        else                    r_arb <= w_rsp.res;
                        for (int k = 0; k < OUT_WORDS; k++) begin
                            if (32'(r_draw) == k) r_words[k] <= w_rsp.res[LCG_W-1:LCG_W-WORD_W];
                        end
                        if (32'(r_draw) == ID_WORDS - 1) begin
                            r_state <= ST_FIN;
                            if (r_mode == MODE_DET) begin
                                if (n_cnt == {1'b0, r_restart_lim}) begin
                                    r_reseed <= 1'b1;
                                    r_cnt    <= CNT_W'(r_start_ofs);
                                end else begin
                                    r_cnt    <= n_cnt;
                                end
                            end
                        end else begin
                            r_draw <= r_draw + 1'b1;
                        end
                    end
                end

                ST_FIN: begin
                    // hand off the result once the output register is free
                    if (w_out_free) begin
                        if (r_reseed) begin
                            r_det      <= DET_RESET;
                            r_ba       <= LCG_MUL;
                            r_bc       <= LCG_ADD;
                            r_n        <= r_start_ofs;
                            r_op       <= OP_DET;
                            r_skip_arb <= 1'b0;
                            r_state    <= ST_SKIP;
                        end else begin
                            r_state    <= ST_IDLE;
                        end
                    end
                end

                ST_SKIP: begin
                    // one offset bit per pass: apply step if bit set, then square
                    if (!r_wait) begin
                        if (r_n == '0) begin
                            r_state <= ST_IDLE;
                        end else if (w_op_need) begin
                            r_wait <= 1'b1;
                        end else begin
                            r_op <= (r_op == OP_DET) ? OP_ARB : OP_BC;
                        end
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        unique case (r_op)
                            OP_DET: begin
                                r_det <= w_rsp.res;
                                r_op  <= OP_ARB;
                            end
                            OP_ARB: begin
                                r_arb <= w_rsp.res;
                                r_op  <= OP_BC;
                            end
                            OP_BC: begin
                                r_bc  <= w_rsp.res;
                                r_op  <= OP_BA;
                            end
                            default: begin
                                r_ba  <= w_rsp.res;
                                r_n   <= r_n >> 1;
                                r_op  <= OP_DET;
                            end
                        endcase
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Ports
    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.out_type  = r_o_type;
    assign o_out.rewritten = r_o_mode;
    assign o_out.word0     = r_o_words[0];
    assign o_out.word1     = r_o_words[1];
    assign o_out.word2     = r_o_words[2];
    assign o_out.word3     = r_o_words[3];
    assign o_out.word4     = r_o_words[4];

    // A new multiply-add is issued only when the unit and the sequencer are free
    `ADRID_ASSERT_IMP(a_mul_issue_free, w_req.start, !r_wait && !w_rsp.busy)
    // The unit only finishes an operation the sequencer waits for
    `ADRID_ASSERT_IMP(a_mul_done_waited, w_rsp.done, r_wait)
    // Draws run only for a rewritten node
    `ADRID_ASSERT_IMP(a_draw_mode, r_state == ST_DRAW, r_mode == MODE_DET || r_mode == MODE_ARB)
    // A skip pass never grows the remaining offset
    `ADRID_ASSERT_NXT(a_skip_shrinks, r_state == ST_SKIP && r_wait,
                      r_n == $past(r_n) || r_n == ($past(r_n) >> 1))

endmodule

/* src/adrid_mul.sv */
// Shared 48-bit multiply-add unit built from one 24x24 multiplier, stepped through the LL, HL and LH phases.
module adrid_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adrid_pkg::t_mul_req i_req,
    output adrid_pkg::t_mul_rsp o_rsp
);
    import adrid_pkg::*;

    typedef enum logic [3:0] {
        MP_IDLE = 4'b0001,
        MP_LL   = 4'b0010,
        MP_HL   = 4'b0100,
        MP_LH   = 4'b1000
    } t_mphase;

    t_mphase           r_ph;
    logic              r_done;
    logic [LCG_W-1:0]  r_a;
    logic [LCG_W-1:0]  r_b;
    logic [LCG_W-1:0]  r_c;
    logic [LCG_W-1:0]  r_acc;

    logic [HALF_W-1:0] w_x;
    logic [HALF_W-1:0] w_y;
    logic [LCG_W-1:0]  w_prod;

    // Operand select: low*low, then the two cross terms (only their low half matters)
    always_comb begin
        unique case (r_ph)
            MP_HL: begin
                w_x = r_a[LCG_W-1:HALF_W];
                w_y = r_b[HALF_W-1:0];
            end
            MP_LH: begin
                w_x = r_a[HALF_W-1:0];
                w_y = r_b[LCG_W-1:HALF_W];
            end
            default: begin
                w_x = r_a[HALF_W-1:0];
                w_y = r_b[HALF_W-1:0];
            end
        endcase
    end

    assign w_prod = w_x * w_y;

    // Phase sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= MP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == MP_LH);
            unique case (r_ph)
                MP_IDLE: if (i_req.start) r_ph <= MP_LL;
                MP_LL:   r_ph <= MP_HL;
                MP_HL:   r_ph <= MP_LH;
                MP_LH:   r_ph <= MP_IDLE;
                default: r_ph <= MP_IDLE;
            endcase
        end
    end

    // Operand capture and accumulation, mod 2^48 by truncation
    always_ff @(posedge i_clk) begin
        if (r_ph == MP_IDLE && i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_c <= i_req.c;
        end
        unique case (r_ph) inside
            MP_LL:        r_acc <= w_prod + r_c;
            MP_HL, MP_LH: r_acc <= r_acc + {w_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            default:      r_acc <= r_acc;
        endcase
    end

    assign o_rsp.busy = (r_ph != MP_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule
